@@ hw/rtl/bezier_keyframe_interpolator_assert.svh @@
// Assertion macros shared by the RTL.
`ifndef BEZIER_KEYFRAME_INTERPOLATOR_ASSERT_SVH
`define BEZIER_KEYFRAME_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication.
`define BKF_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BKF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/bkf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bkf_pkg;

   localparam int QUO_WIDTH   = 16;
   localparam int T_WIDTH     = QUO_WIDTH + 1;
   localparam int TONE_SHIFT  = 16;
   localparam logic [T_WIDTH-1:0] TONE = T_WIDTH'(1) << TONE_SHIFT;
   localparam int LERP_STAGES = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic signed [31:0] DEFAULT_Z_RESET = 32'sd65536;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEFAULT_X = 2'd0,
      CSR_DEFAULT_Y = 2'd1,
      CSR_DEFAULT_Z = 2'd2,
      CSR_X_ENABLED = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

endpackage
`default_nettype wire

@@ hw/rtl/bkf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage. Requires num < den.
module bkf_div #(
   parameter int FRAME_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic [bkf_pkg::QUO_WIDTH-1:0]  en,
   input  wire logic [FRAME_WIDTH-1:0]         num,
   input  wire logic [FRAME_WIDTH-1:0]         den,
   output logic      [bkf_pkg::QUO_WIDTH-1:0]  quo
);

   localparam int NS = bkf_pkg::QUO_WIDTH;

   logic [FRAME_WIDTH-1:0] rem_ff [NS];
   logic [FRAME_WIDTH-1:0] den_ff [NS-1];
   logic [NS-1:0]          quo_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic [FRAME_WIDTH-1:0] r_src;
      logic [FRAME_WIDTH-1:0] d_src;
      logic [NS-1:0]          q_src;
      logic [FRAME_WIDTH:0]   shl;
      logic [FRAME_WIDTH:0]   dif;
      logic                   take;
      logic [FRAME_WIDTH-1:0] rem_in;
      logic [NS-1:0]          quo_in;

      if (i == 0) begin : g_first
         assign r_src = num;
         assign d_src = den;
         assign q_src = '0;
      end else begin : g_next
         assign r_src = rem_ff[i-1];
         assign d_src = den_ff[i-1];
         assign q_src = quo_ff[i-1];
      end

      assign shl    = {r_src, 1'b0};
      assign dif    = shl - {1'b0, d_src};
      assign take   = (shl >= {1'b0, d_src});
      assign rem_in = take ? dif[FRAME_WIDTH-1:0] : shl[FRAME_WIDTH-1:0];
      assign quo_in = {q_src[NS-2:0], take};

      always_ff @(posedge clock) begin
         if (en[i]) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
         end
      end

      if (i < NS - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en[i]) begin
               den_ff[i] <= d_src;
            end
         end
      end
   end

   assign quo = quo_ff[NS-1];

endmodule
`default_nettype wire

@@ hw/rtl/bkf_lerp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One de Casteljau level: y = a + floor((b - a) * t / 2^16), three stages.
module bkf_lerp #(
   parameter int LANES = 3,
   parameter int W     = 33
) (
   input  wire logic                                clock,
   input  wire logic [bkf_pkg::LERP_STAGES-1:0]     en,
   input  wire logic [bkf_pkg::T_WIDTH-1:0]         t_in,
   input  wire logic signed [W-1:0]                 a_in [LANES],
   input  wire logic signed [W-1:0]                 b_in [LANES],
   output logic      [bkf_pkg::T_WIDTH-1:0]         t_out,
   output logic signed [W-1:0]                      y_out [LANES]
);

   localparam int TW  = bkf_pkg::T_WIDTH;
   localparam int PRW = W + TW + 2;

   logic [TW-1:0] t_a_ff;
   logic [TW-1:0] t_b_ff;
   logic [TW-1:0] t_c_ff;

   always_ff @(posedge clock) begin
      if (en[0]) t_a_ff <= t_in;
      if (en[1]) t_b_ff <= t_a_ff;
      if (en[2]) t_c_ff <= t_b_ff;
   end

   assign t_out = t_c_ff;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic signed [W-1:0]   a_a_ff;
      logic signed [W:0]     d_a_ff;
      logic signed [W:0]     d_a_in;
      logic signed [W-1:0]   a_b_ff;
      logic signed [PRW-1:0] p_b_ff;
      logic signed [PRW-1:0] p_b_in;
      logic signed [PRW-1:0] sum;
      logic signed [W-1:0]   y_ff;

      assign d_a_in = (W+1)'(b_in[i]) - (W+1)'(a_in[i]);
      assign p_b_in = d_a_ff * $signed({1'b0, t_a_ff});
      assign sum    = PRW'(a_b_ff) + (p_b_ff >>> bkf_pkg::TONE_SHIFT);

      always_ff @(posedge clock) begin
         if (en[0]) begin
            a_a_ff <= a_in[i];
            d_a_ff <= d_a_in;
         end
         if (en[1]) begin
            a_b_ff <= a_a_ff;
            p_b_ff <= p_b_in;
         end
         if (en[2]) begin
            y_ff <= sum[W-1:0];
         end
      end

      assign y_out[i] = y_ff;
   end

endmodule
`default_nettype wire

@@ hw/rtl/bezier_keyframe_interpolator.sv @@
// Throughput: one beat per cycle while rsp_stall is low; 16 divider stages and
// three 3-stage lerp levels, each stage moving independently so bubbles
// collapse under stall.
// Reset (synchronous, active high) empties the pipeline and restores the
// axis defaults (0, 0, 1.0) and x enabled.
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_keyframe_interpolator_assert.svh"
module bezier_keyframe_interpolator #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAME_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [bkf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [COORD_WIDTH-1:0]                 csr_data,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_axis,
   input  wire logic [FRAME_WIDTH-1:0]                 req_query_frame,
   input  wire logic [FRAME_WIDTH-1:0]                 req_before_frame,
   input  wire logic [FRAME_WIDTH-1:0]                 req_after_frame,
   input  wire logic                                   req_has_before,
   input  wire logic                                   req_has_after,
   input  wire logic signed [COORD_WIDTH-1:0]          req_before_center,
   input  wire logic signed [COORD_WIDTH-1:0]          req_before_out_offset,
   input  wire logic signed [COORD_WIDTH-1:0]          req_after_center,
   input  wire logic signed [COORD_WIDTH-1:0]          req_after_in_offset,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [COORD_WIDTH-1:0]               rsp_value,
   output logic                                        rsp_updated
);

   localparam int PW     = COORD_WIDTH + 1;
   localparam int TW     = bkf_pkg::T_WIDTH;
   localparam int NDIV   = bkf_pkg::QUO_WIDTH;
   localparam int LS     = bkf_pkg::LERP_STAGES;
   localparam int L1     = NDIV + 1;
   localparam int L2     = L1 + LS;
   localparam int L3     = L2 + LS;
   localparam int OUT_ST = L3 + LS;
   localparam int NST    = OUT_ST + 1;

   typedef struct packed {
      logic                   blend;
      logic                   upd;
      logic                   lo_clamp;
      logic                   hi_clamp;
      logic [COORD_WIDTH-1:0] direct;
   } side_type;

   // configuration
   logic [COORD_WIDTH-1:0] default_x_ff;
   logic [COORD_WIDTH-1:0] default_y_ff;
   logic [COORD_WIDTH-1:0] default_z_ff;
   logic                   x_enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_x_ff <= '0;
         default_y_ff <= '0;
         default_z_ff <= COORD_WIDTH'(bkf_pkg::DEFAULT_Z_RESET);
         x_enabled_ff <= 1'b1;
      end else if (csr_write) begin
         case (bkf_pkg::csr_index_type'(csr_index))
            bkf_pkg::CSR_DEFAULT_X: default_x_ff <= csr_data;
            bkf_pkg::CSR_DEFAULT_Y: default_y_ff <= csr_data;
            bkf_pkg::CSR_DEFAULT_Z: default_z_ff <= csr_data;
            bkf_pkg::CSR_X_ENABLED: x_enabled_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NST-1:0] v_ff;
   logic [NST-1:0] rdy;

   always_comb begin
      rdy[NST-1] = !v_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_stall = !rdy[0];

   // decode
   side_type              side_in;
   logic signed [PW-1:0]  pt_in [4];
   logic [FRAME_WIDTH-1:0] num_in;
   logic [FRAME_WIDTH-1:0] den_in;

   always_comb begin
      side_in.blend    = 1'b0;
      side_in.upd      = 1'b1;
      side_in.lo_clamp = (req_query_frame <= req_before_frame);
      side_in.hi_clamp = (req_query_frame >= req_after_frame);
      side_in.direct   = '0;
      if (!req_has_before && !req_has_after) begin
         case (req_axis)
            bkf_pkg::AXIS_X: side_in.direct = default_x_ff;
            bkf_pkg::AXIS_Y: side_in.direct = default_y_ff;
            default:         side_in.direct = default_z_ff;
         endcase
      end else if (req_has_before &&
                   (!req_has_after || req_query_frame == req_before_frame)) begin
         side_in.direct = req_before_center;
      end else if (!req_has_before || req_query_frame == req_after_frame) begin
         side_in.direct = req_after_center;
      end else if (req_axis == bkf_pkg::AXIS_X && !x_enabled_ff) begin
         side_in.upd = 1'b0;
      end else begin
         side_in.blend = 1'b1;
      end
   end

   assign pt_in[0] = PW'(req_before_center);
   assign pt_in[1] = PW'(req_before_center) + PW'(req_before_out_offset);
   assign pt_in[2] = PW'(req_after_center) + PW'(req_after_in_offset);
   assign pt_in[3] = PW'(req_after_center);
   assign num_in   = req_query_frame - req_before_frame;
   assign den_in   = req_after_frame - req_before_frame;

   side_type               side_ff [OUT_ST];
   logic signed [PW-1:0]   pt_ff   [L1][4];
   logic [FRAME_WIDTH-1:0] num_ff;
   logic [FRAME_WIDTH-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0] <= side_in;
         pt_ff[0]   <= pt_in;
         num_ff     <= num_in;
         den_ff     <= den_in;
      end
      for (int k = 1; k < OUT_ST; k++) begin
         if (rdy[k]) side_ff[k] <= side_ff[k-1];
      end
      for (int k = 1; k < L1; k++) begin
         if (rdy[k]) pt_ff[k] <= pt_ff[k-1];
      end
   end

   // t = (f - f0) * 2^16 / (f1 - f0)
   logic [NDIV-1:0] quo;

   bkf_div #(
      .FRAME_WIDTH(FRAME_WIDTH)
   ) u_div (
      .clock (clock),
      .en    (rdy[NDIV:1]),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo)
   );

   logic [TW-1:0] t0;

   always_comb begin
      if (side_ff[L1-1].lo_clamp) begin
         t0 = '0;
      end else if (side_ff[L1-1].hi_clamp) begin
         t0 = bkf_pkg::TONE;
      end else begin
         t0 = {1'b0, quo};
      end
   end

   // de Casteljau
   logic signed [PW-1:0] l1_a [3];
   logic signed [PW-1:0] l1_b [3];
   logic signed [PW-1:0] l1_y [3];
   logic signed [PW-1:0] l2_a [2];
   logic signed [PW-1:0] l2_b [2];
   logic signed [PW-1:0] l2_y [2];
   logic signed [PW-1:0] l3_a [1];
   logic signed [PW-1:0] l3_b [1];
   logic signed [PW-1:0] l3_y [1];
   logic [TW-1:0]        l1_t;
   logic [TW-1:0]        l2_t;
   logic [TW-1:0]        l3_t;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         l1_a[i] = pt_ff[L1-1][i];
         l1_b[i] = pt_ff[L1-1][i+1];
      end
      for (int i = 0; i < 2; i++) begin
         l2_a[i] = l1_y[i];
         l2_b[i] = l1_y[i+1];
      end
      l3_a[0] = l2_y[0];
      l3_b[0] = l2_y[1];
   end

   bkf_lerp #(.LANES(3), .W(PW)) u_lerp1 (
      .clock (clock),
      .en    (rdy[L1+LS-1:L1]),
      .t_in  (t0),
      .a_in  (l1_a),
      .b_in  (l1_b),
      .t_out (l1_t),
      .y_out (l1_y)
   );

   bkf_lerp #(.LANES(2), .W(PW)) u_lerp2 (
      .clock (clock),
      .en    (rdy[L2+LS-1:L2]),
      .t_in  (l1_t),
      .a_in  (l2_a),
      .b_in  (l2_b),
      .t_out (l2_t),
      .y_out (l2_y)
   );

   bkf_lerp #(.LANES(1), .W(PW)) u_lerp3 (
      .clock (clock),
      .en    (rdy[L3+LS-1:L3]),
      .t_in  (l2_t),
      .a_in  (l3_a),
      .b_in  (l3_b),
      .t_out (l3_t),
      .y_out (l3_y)
   );

   // saturate and select
   logic [COORD_WIDTH-1:0] sat;
   logic [COORD_WIDTH-1:0] value_in;
   logic [COORD_WIDTH-1:0] value_ff;
   logic                   updated_ff;

   always_comb begin
      if (l3_y[0][PW-1] != l3_y[0][PW-2]) begin
         sat = l3_y[0][PW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                             : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         sat = l3_y[0][COORD_WIDTH-1:0];
      end
      value_in = side_ff[OUT_ST-1].blend ? sat : side_ff[OUT_ST-1].direct;
   end

   always_ff @(posedge clock) begin
      if (rdy[OUT_ST]) begin
         value_ff   <= value_in;
         updated_ff <= side_ff[OUT_ST-1].upd;
      end
   end

   assign rsp_valid   = v_ff[OUT_ST];
   assign rsp_value   = value_ff;
   assign rsp_updated = updated_ff;

   `BKF_ASSERT_IMPLY(a_not_updated_zero, clock, reset,
      rsp_valid && !rsp_updated, rsp_value == '0, "not-updated beat has nonzero value")
   `BKF_ASSERT_IMPLY(a_accept_has_room, clock, reset,
      !req_stall, !(&v_ff) || !rsp_stall, "input taken while pipeline full and stalled")
   `BKF_ASSERT_NEXT(a_head_advances, clock, reset,
      v_ff[0] && rdy[1], v_ff[1], "beat lost between decode and divider")
   `BKF_ASSERT_NEXT(a_rsp_held, clock, reset,
      rsp_valid && rsp_stall && !reset, rsp_valid && $stable(value_ff),
      "stalled result changed")

endmodule
`default_nettype wire
